// ----- rtl/terminfo_entry_deframer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the terminfo entry deframer
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TERMINFO_ENTRY_DEFRAMER_UNIT_MACROS_SVH
`define TERMINFO_ENTRY_DEFRAMER_UNIT_MACROS_SVH

// plain property
`define TEDF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// same-cycle implication
`define TEDF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/tedf_pkg.sv -----
// ----------------------------------------------------------------------------
// tedf_pkg
// Shared types and constants of the terminfo entry deframer.
// ----------------------------------------------------------------------------
package tedf_pkg;

   localparam logic [15:0] MAGIC_NARROW = 16'h011A;
   localparam logic [15:0] MAGIC_WIDE   = 16'h021E;
   localparam int          HEADER_LEN   = 12;

   localparam int QDEPTH = 4;
   localparam int QPTRW  = $clog2(QDEPTH);
   localparam int QCNTW  = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAMES,
      PH_BOOLS,
      PH_PAD,
      PH_NUMS,
      PH_SOFFS,
      PH_STRTAB,
      PH_TAIL
   } phase_type;

   typedef enum logic [2:0] {
      KIND_BOOL,
      KIND_NUM,
      KIND_SOFF,
      KIND_STRB,
      KIND_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_MAGIC,
      ST_NEG,
      ST_TRUNC
   } sts_type;

   // results of one input item: an optional record, then an optional end status
   typedef struct packed {
      logic        has_rec;
      kind_type    kind;
      logic [14:0] idx;
      logic [31:0] value;
      logic        ofs_ok;
      logic        has_sts;
      sts_type     sts;
   } entry_type;

endpackage

// ----- rtl/terminfo_entry_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// terminfo_entry_deframer_unit
// Compiled terminfo entry deframer: parses a byte stream into boolean,
// number, string offset and string table records plus an end status.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    data_byte, final_byte
//   rsp      out  rsp_valid/stall    record_kind, entry_index, entry_value,
//                                    offset_valid, status, run_end
//
// One byte is accepted per cycle while req_stall is low; the parser turns it around in that cycle.
// A byte with a record and an end status yields two results, sent one at a time by the
// single output register; a 4-entry queue absorbs the difference.
// Synchronous reset, no clearing pass.
// req_stall rises only when the queue is full; rsp_stall holds the output.
// ----------------------------------------------------------------------------
module terminfo_entry_deframer_unit #(
   parameter int MAX_BOOLS = 44,
   parameter int MAX_NUMS  = 39,
   parameter int MAX_STRS  = 414,
   parameter int MAX_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_final_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_record_kind,
   output logic [14:0]        rsp_entry_index,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_offset_valid,
   output logic [2:0]         rsp_status,
   output logic               rsp_run_end
);
   import tedf_pkg::*;

   logic      take;
   logic      push;
   entry_type push_entry;
   logic      q_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   tedf_front #(
      .MAX_BOOLS (MAX_BOOLS),
      .MAX_NUMS  (MAX_NUMS),
      .MAX_STRS  (MAX_STRS),
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_data_byte),
      .in_final   (req_final_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   tedf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tedf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_offset_valid (rsp_offset_valid),
      .rsp_status       (rsp_status),
      .rsp_run_end      (rsp_run_end)
   );

endmodule

// ----- rtl/tedf_front.sv -----
// ----------------------------------------------------------------------------
// tedf_front
// Byte parser: tracks header, sections and element assembly, and builds one
// queue entry per item that has results.
// ----------------------------------------------------------------------------
module tedf_front #(
   parameter int MAX_BOOLS = 44,
   parameter int MAX_NUMS  = 39,
   parameter int MAX_STRS  = 414,
   parameter int MAX_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          in_byte,
   input  logic                in_final,
   output logic                push,
   output tedf_pkg::entry_type push_entry
);
   import tedf_pkg::*;

   localparam int BPW = $clog2(MAX_BYTES + 1);

   phase_type         phase_ff, phase_in;
   logic [BPW-1:0]    pos_ff, pos_in;
   logic [5:0][15:0]  hdr_ff, hdr_in;
   logic              wide_ff, wide_in;
   logic [14:0]       cnt_ff, cnt_in;
   logic [31:0]       va_ff, va_in;
   logic [1:0]        bie_ff, bie_in;
   sts_type           err_ff, err_in;
   logic              fin_el;
   logic [15:0]       ofs;

   function automatic logic [31:0] sext8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   function automatic logic [31:0] sext16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [15:0] sec_len(phase_type ph, logic [5:0][15:0] h);
      logic [15:0] r;
      case (ph)
         PH_NAMES:  r = h[1];
         PH_BOOLS:  r = h[2];
         PH_PAD:    r = {15'd0, h[1][0] ^ h[2][0]};
         PH_NUMS:   r = h[3];
         PH_SOFFS:  r = h[4];
         PH_STRTAB: r = h[5];
         default:   r = 16'd1;
      endcase
      return r;
   endfunction

   // first non-empty section at or after ph
   function automatic phase_type first_sec(phase_type ph, logic [5:0][15:0] h);
      phase_type p;
      p = ph;
      for (int k = 0; k < 6; k++) begin
         if (p != PH_TAIL && sec_len(p, h) == 16'd0) begin
            p = phase_type'(3'(p) + 3'd1);
         end
      end
      return p;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= '0;
         hdr_ff   <= '0;
         wide_ff  <= 1'b0;
         cnt_ff   <= '0;
         va_ff    <= '0;
         bie_ff   <= '0;
         err_ff   <= ST_OK;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         hdr_ff   <= hdr_in;
         wide_ff  <= wide_in;
         cnt_ff   <= cnt_in;
         va_ff    <= va_in;
         bie_ff   <= bie_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      hdr_in     = hdr_ff;
      wide_in    = wide_ff;
      cnt_in     = cnt_ff;
      va_in      = va_ff;
      bie_in     = bie_ff;
      err_in     = err_ff;
      fin_el     = 1'b0;
      push_entry = '0;
      ofs        = {in_byte, va_ff[7:0]};
      push       = 1'b0;

      if (take) begin
         if (pos_ff < BPW'(MAX_BYTES)) begin
            pos_in = pos_ff + 1'b1;
            unique case (phase_ff)
               PH_HEADER: begin
                  if (pos_ff[0]) begin
                     hdr_in[pos_ff[3:1]][15:8] = in_byte;
                  end else begin
                     hdr_in[pos_ff[3:1]][7:0] = in_byte;
                  end
                  if (pos_ff == BPW'(HEADER_LEN - 1)) begin
                     if (hdr_in[0] == MAGIC_NARROW) begin
                        wide_in = 1'b0;
                     end else if (hdr_in[0] == MAGIC_WIDE) begin
                        wide_in = 1'b1;
                     end else begin
                        err_in = ST_MAGIC;
                     end
                     if (err_in == ST_OK && (hdr_in[1][15] || hdr_in[2][15] ||
                         hdr_in[3][15] || hdr_in[4][15] || hdr_in[5][15])) begin
                        err_in = ST_NEG;
                     end
                     if (err_in != ST_OK) begin
                        phase_in = PH_TAIL;
                     end else begin
                        phase_in = first_sec(PH_NAMES, hdr_in);
                        cnt_in   = '0;
                        bie_in   = '0;
                        va_in    = '0;
                     end
                  end
               end
               PH_NAMES, PH_PAD: begin
                  fin_el = 1'b1;
               end
               PH_BOOLS: begin
                  if ({1'b0, cnt_ff} < 16'(MAX_BOOLS)) begin
                     push_entry.has_rec = 1'b1;
                     push_entry.kind    = KIND_BOOL;
                     push_entry.idx     = cnt_ff;
                     push_entry.value   = sext8(in_byte);
                  end
                  fin_el = 1'b1;
               end
               PH_NUMS: begin
                  va_in = va_ff | (32'(in_byte) << {bie_ff, 3'b000});
                  if (bie_ff == (wide_ff ? 2'd3 : 2'd1)) begin
                     if ({1'b0, cnt_ff} < 16'(MAX_NUMS)) begin
                        push_entry.has_rec = 1'b1;
                        push_entry.kind    = KIND_NUM;
                        push_entry.idx     = cnt_ff;
                        push_entry.value   = wide_ff ? {in_byte, va_ff[23:0]}
                                                     : sext16({in_byte, va_ff[7:0]});
                     end
                     fin_el = 1'b1;
                  end else begin
                     bie_in = bie_ff + 2'd1;
                  end
               end
               PH_SOFFS: begin
                  if (bie_ff[0]) begin
                     if ({1'b0, cnt_ff} < 16'(MAX_STRS)) begin
                        push_entry.has_rec = 1'b1;
                        push_entry.kind    = KIND_SOFF;
                        push_entry.idx     = cnt_ff;
                        push_entry.value   = sext16(ofs);
                        push_entry.ofs_ok  = !ofs[15] && (ofs < hdr_ff[5]);
                     end
                     fin_el = 1'b1;
                  end else begin
                     va_in  = {24'd0, in_byte};
                     bie_in = 2'd1;
                  end
               end
               PH_STRTAB: begin
                  push_entry.has_rec = 1'b1;
                  push_entry.kind    = KIND_STRB;
                  push_entry.idx     = cnt_ff;
                  push_entry.value   = sext8(in_byte);
                  fin_el = 1'b1;
               end
               PH_TAIL: begin
               end
            endcase

            if (fin_el) begin
               cnt_in = cnt_ff + 15'd1;
               bie_in = '0;
               va_in  = '0;
               if ({1'b0, cnt_in} >= sec_len(phase_ff, hdr_ff)) begin
                  phase_in = first_sec(phase_type'(3'(phase_ff) + 3'd1), hdr_ff);
                  cnt_in   = '0;
               end
            end
         end

         if (in_final) begin
            push_entry.has_sts = 1'b1;
            if (pos_in < BPW'(HEADER_LEN)) begin
               push_entry.sts = ST_SHORT;
            end else if (err_in != ST_OK) begin
               push_entry.sts = err_in;
            end else if (phase_in != PH_TAIL) begin
               push_entry.sts = ST_TRUNC;
            end else begin
               push_entry.sts = ST_OK;
            end
            phase_in = PH_HEADER;
            pos_in   = '0;
            hdr_in   = '0;
            wide_in  = 1'b0;
            cnt_in   = '0;
            va_in    = '0;
            bie_in   = '0;
            err_in   = ST_OK;
         end

         push = push_entry.has_rec | push_entry.has_sts;
      end
   end

endmodule

// ----- rtl/tedf_queue.sv -----
// ----------------------------------------------------------------------------
// tedf_queue
// Short register queue between the parser and the record sender.
// ----------------------------------------------------------------------------
`include "terminfo_entry_deframer_unit_macros.svh"

module tedf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tedf_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tedf_pkg::entry_type head_entry
);
   import tedf_pkg::*;

   entry_type        slot_ff [QDEPTH];
   logic [QPTRW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTRW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNTW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = push ? QPTRW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTRW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign full       = (count_ff == QCNTW'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   `TEDF_ASSERT_IMP(a_no_push_full, push, !full, "item pushed into full queue")
   `TEDF_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "pop from empty queue")
   `TEDF_ASSERT(a_push_fills, (push && !pop) |=> (count_ff != '0), "queue lost an entry")

endmodule

// ----- rtl/tedf_back.sv -----
// ----------------------------------------------------------------------------
// tedf_back
// Record sender: turns each queue entry into one or two results behind an
// output register.
// ----------------------------------------------------------------------------
`include "terminfo_entry_deframer_unit_macros.svh"

module tedf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  tedf_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_record_kind,
   output logic [14:0]         rsp_entry_index,
   output logic signed [31:0]  rsp_entry_value,
   output logic                rsp_offset_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_run_end
);
   import tedf_pkg::*;

   logic        valid_ff, valid_in;
   logic        sub_ff, sub_in;
   kind_type    kind_ff, kind_in;
   logic [14:0] idx_ff, idx_in;
   logic [31:0] value_ff, value_in;
   logic        ofs_ok_ff, ofs_ok_in;
   sts_type     sts_ff, sts_in;
   logic        run_end_ff, run_end_in;
   logic        out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      ofs_ok_ff  <= ofs_ok_in;
      sts_ff     <= sts_in;
      run_end_ff <= run_end_in;
   end

   always_comb begin
      out_free   = !valid_ff || !rsp_stall;
      valid_in   = valid_ff && rsp_stall;
      sub_in     = sub_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      value_in   = value_ff;
      ofs_ok_in  = ofs_ok_ff;
      sts_in     = sts_ff;
      run_end_in = run_end_ff;
      pop        = 1'b0;

      if (head_valid && out_free) begin
         valid_in = 1'b1;
         if (head_entry.has_rec && !sub_ff) begin
            kind_in    = head_entry.kind;
            idx_in     = head_entry.idx;
            value_in   = head_entry.value;
            ofs_ok_in  = head_entry.ofs_ok;
            sts_in     = ST_OK;
            run_end_in = !head_entry.has_sts;
            sub_in     = head_entry.has_sts;
            pop        = !head_entry.has_sts;
         end else begin
            kind_in    = KIND_END;
            idx_in     = '0;
            value_in   = '0;
            ofs_ok_in  = 1'b0;
            sts_in     = head_entry.sts;
            run_end_in = 1'b1;
            sub_in     = 1'b0;
            pop        = 1'b1;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_record_kind  = 3'(kind_ff);
   assign rsp_entry_index  = idx_ff;
   assign rsp_entry_value  = value_ff;
   assign rsp_offset_valid = ofs_ok_ff;
   assign rsp_status       = 3'(sts_ff);
   assign rsp_run_end      = run_end_ff;

   `TEDF_ASSERT_IMP(a_sub_has_head, sub_ff, head_valid, "split entry left the queue early")
   `TEDF_ASSERT_IMP(a_end_is_last, valid_ff && kind_ff == KIND_END, run_end_ff,
      "end status not marked last")
   `TEDF_ASSERT_IMP(a_pop_when_free, pop, out_free, "entry popped into a busy output")

endmodule
